// File: hw/rtl/fpsnr_pkg.sv
// fpsnr_pkg: constants, register indexes and depth tables of the frame psnr accumulator
// used by every rtl file of the block; depends on nothing
`timescale 1ns / 1ps

package fpsnr_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int DIM_W      = 13;
	localparam int N_W        = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int CNT_W      = N_W - 1;
	localparam int SSE_W      = 56;
	localparam int LOG_FRAC   = 28;
	localparam int EXP_W      = 6;
	localparam int LOG_W      = EXP_W + LOG_FRAC;
	localparam int MUL_W      = 32;
	localparam int SCORE_W    = 24;
	localparam int SAMPLE_W   = 16;
	localparam int HALF_W     = 17;

	localparam logic [MUL_W-1:0]    DB_PER_OCTAVE_Q28 = 32'd808071242;
	localparam logic [DIM_W-1:0]    WIDTH_RESET       = 13'd1920;
	localparam logic [DIM_W-1:0]    HEIGHT_RESET      = 13'd1080;
	localparam logic [EXP_W-1:0]    EXP_TOP           = 6'(SSE_W - 1);

	typedef enum logic [1:0] {
		CFG_DEPTH    = 2'd0,
		CFG_UNCAPPED = 2'd1,
		CFG_WIDTH    = 2'd2,
		CFG_HEIGHT   = 2'd3
	} cfg_idx_t;

	// sample mask, i.e. peak value, per depth mode
	function automatic logic [SAMPLE_W-1:0] depth_peak(input logic [1:0] mode);
		logic [SAMPLE_W-1:0] p;
		case (mode)
			2'd0:    p = 16'h00FF;
			2'd1:    p = 16'h03FF;
			2'd2:    p = 16'h0FFF;
			default: p = 16'hFFFF;
		endcase
		return p;
	endfunction

	// cap in Q8.16 dB per depth mode
	function automatic logic [SCORE_W-1:0] depth_cap(input logic [1:0] mode);
		logic [7:0] db;
		case (mode)
			2'd0:    db = 8'd60;
			2'd1:    db = 8'd72;
			2'd2:    db = 8'd84;
			default: db = 8'd108;
		endcase
		return {db, 16'h0000};
	endfunction

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] maxv);
		logic [DIM_W-1:0] r;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > maxv)
			r = maxv;
		else
			r = v;
		return r;
	endfunction

endpackage

// File: hw/rtl/fpsnr_in_if.sv
// fpsnr_in_if: sample pair channel, valid/ready handshake
// depends on fpsnr_pkg
`timescale 1ns / 1ps

interface fpsnr_in_if;
	logic                               valid;
	logic                               ready;
	logic [fpsnr_pkg::SAMPLE_W-1:0]     ref_sample;
	logic [fpsnr_pkg::SAMPLE_W-1:0]     dist_sample;

	modport source (output valid, output ref_sample, output dist_sample, input ready);
	modport sink (input valid, input ref_sample, input dist_sample, output ready);
endinterface

// File: hw/rtl/fpsnr_out_if.sv
// fpsnr_out_if: frame score channel, valid/ready handshake
// depends on fpsnr_pkg
`timescale 1ns / 1ps

interface fpsnr_out_if;
	logic                               valid;
	logic                               ready;
	logic [fpsnr_pkg::SCORE_W-1:0]      psnr_score;
	logic                               lossless;

	modport source (output valid, output psnr_score, output lossless, input ready);
	modport sink (input valid, input psnr_score, input lossless, output ready);
endinterface

// File: hw/rtl/fpsnr_mul.sv
// fpsnr_mul: shared 32x32 unsigned multiplier used by the square, frame size, peak, log2 and dB scaling steps
// depends on fpsnr_pkg
`timescale 1ns / 1ps

module fpsnr_mul (
	input  logic [fpsnr_pkg::MUL_W-1:0]   op_a,
	input  logic [fpsnr_pkg::MUL_W-1:0]   op_b,
	output logic [2*fpsnr_pkg::MUL_W-1:0] prod
);
	assign prod = (2*fpsnr_pkg::MUL_W)'(op_a) * (2*fpsnr_pkg::MUL_W)'(op_b);
endmodule

// File: hw/rtl/frame_psnr_accumulator_unit.sv
// frame_psnr_accumulator_unit: per-frame sse accumulation and psnr via log2 sequencer
// depends on fpsnr_pkg, fpsnr_in_if, fpsnr_out_if, fpsnr_mul
// a sample request runs through diff, square/accumulate and frame size product steps
// on the last pixel with nonzero sse the sequencer takes log2 of peak^2*n and of sse by
// normalize and squaring rounds on the shared multiplier, then scales to dB; ready is low meanwhile
// the score waits in an output register, so new samples are taken while it is pending
// arst_n clears sums, sequencer and output valid and loads register reset values
`timescale 1ns / 1ps

module frame_psnr_accumulator_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_index,
	input  logic [fpsnr_pkg::DIM_W-1:0]    cfg_data,
	fpsnr_in_if.sink                       sample_in,
	fpsnr_out_if.source                    score_out
);
	localparam int MW = fpsnr_pkg::MUL_W;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SQ, ST_CNT, ST_PK, ST_PA, ST_NORM, ST_ITER, ST_MH, ST_ML, ST_FIN
	} state_t;

	state_t                              state_q;
	logic [1:0]                          mode_q;
	logic                                unc_q;
	logic [fpsnr_pkg::DIM_W-1:0]         w_q, h_q;
	logic [fpsnr_pkg::SAMPLE_W-1:0]      diff_q;
	logic [fpsnr_pkg::SSE_W-1:0]         sse_q;
	logic [fpsnr_pkg::CNT_W-1:0]         cnt_q;
	logic [MW-1:0]                       pp_q;
	logic [fpsnr_pkg::N_W-1:0]           n_q;
	logic [fpsnr_pkg::SSE_W-1:0]         x_q;
	logic [fpsnr_pkg::EXP_W-1:0]         e_q;
	logic [fpsnr_pkg::LOG_FRAC-1:0]      frac_q;
	logic [MW-1:0]                       m_q;
	logic [4:0]                          rnd_q;
	logic                                which_q;
	logic [fpsnr_pkg::LOG_W-1:0]         la_q, dq_q;
	logic [46:0]                         ph_q;
	logic [fpsnr_pkg::SCORE_W-1:0]       sc_q;
	logic                                zero_q, loss_q;
	logic                                out_valid_q;
	logic [fpsnr_pkg::SCORE_W-1:0]       out_score_q;
	logic                                out_loss_q;

	logic [MW-1:0]                       op_a, op_b;
	logic [2*MW-1:0]                     prod;
	logic [fpsnr_pkg::SAMPLE_W-1:0]      peak, rs, ds;
	logic [fpsnr_pkg::DIM_W-1:0]         wc, hc;
	logic [fpsnr_pkg::N_W-1:0]           n_now, cnt_next;
	logic [fpsnr_pkg::LOG_FRAC-1:0]      frac_next;
	logic [fpsnr_pkg::LOG_W-1:0]         log_val;
	logic [2*MW-1:0]                     total;
	logic [fpsnr_pkg::SCORE_W-1:0]       cap, capped;

	assign peak = fpsnr_pkg::depth_peak(mode_q);
	assign cap  = fpsnr_pkg::depth_cap(mode_q);
	assign rs   = sample_in.ref_sample & peak;
	assign ds   = sample_in.dist_sample & peak;
	assign wc   = fpsnr_pkg::clamp_dim(w_q, fpsnr_pkg::DIM_W'(fpsnr_pkg::MAX_WIDTH));
	assign hc   = fpsnr_pkg::clamp_dim(h_q, fpsnr_pkg::DIM_W'(fpsnr_pkg::MAX_HEIGHT));

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (state_q)
			ST_SQ: begin
				op_a = MW'(diff_q);
				op_b = MW'(diff_q);
			end
			ST_CNT: begin
				op_a = MW'(wc);
				op_b = MW'(hc);
			end
			ST_PK: begin
				op_a = MW'(peak);
				op_b = MW'(peak);
			end
			ST_PA: begin
				op_a = pp_q;
				op_b = MW'(n_q);
			end
			ST_ITER: begin
				op_a = m_q;
				op_b = m_q;
			end
			ST_MH: begin
				op_a = MW'(dq_q[fpsnr_pkg::LOG_W-1:fpsnr_pkg::HALF_W]);
				op_b = fpsnr_pkg::DB_PER_OCTAVE_Q28;
			end
			ST_ML: begin
				op_a = MW'(dq_q[fpsnr_pkg::HALF_W-1:0]);
				op_b = fpsnr_pkg::DB_PER_OCTAVE_Q28;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	fpsnr_mul u_mul (
		.op_a (op_a),
		.op_b (op_b),
		.prod (prod)
	);

	assign n_now     = prod[fpsnr_pkg::N_W-1:0];
	assign cnt_next  = fpsnr_pkg::N_W'(cnt_q) + fpsnr_pkg::N_W'(1);
	assign frac_next = {frac_q[fpsnr_pkg::LOG_FRAC-2:0], prod[2*MW-1]};
	assign log_val   = {e_q, frac_next};
	assign total     = {ph_q, {fpsnr_pkg::HALF_W{1'b0}}} + (2*MW)'(prod[46:0])
			+ ((2*MW)'(1) << 39);

	always_comb begin
		if (zero_q)
			capped = '0;
		else
			capped = sc_q;
		if (!unc_q && capped > cap)
			capped = cap;
	end

	assign sample_in.ready      = (state_q == ST_IDLE);
	assign score_out.valid      = out_valid_q;
	assign score_out.psnr_score = out_score_q;
	assign score_out.lossless   = out_loss_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
			unc_q  <= 1'b0;
			w_q    <= fpsnr_pkg::WIDTH_RESET;
			h_q    <= fpsnr_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				fpsnr_pkg::CFG_DEPTH:    mode_q <= cfg_data[1:0];
				fpsnr_pkg::CFG_UNCAPPED: unc_q  <= cfg_data[0];
				fpsnr_pkg::CFG_WIDTH:    w_q    <= cfg_data;
				fpsnr_pkg::CFG_HEIGHT:   h_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sse_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			rnd_q       <= '0;
			which_q     <= 1'b0;
			zero_q      <= 1'b0;
			loss_q      <= 1'b0;
		end else begin
			if (out_valid_q && score_out.ready && state_q != ST_FIN)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (sample_in.valid) begin
						diff_q  <= (rs >= ds) ? (rs - ds) : (ds - rs);
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					sse_q   <= sse_q + prod[fpsnr_pkg::SSE_W-1:0];
					state_q <= ST_CNT;
				end
				ST_CNT: begin
					n_q    <= n_now;
					zero_q <= 1'b0;
					loss_q <= (sse_q == '0);
					if (cnt_next < n_now) begin
						cnt_q   <= cnt_q + fpsnr_pkg::CNT_W'(1);
						state_q <= ST_IDLE;
					end else if (sse_q == '0) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_PK;
					end
				end
				ST_PK: begin
					pp_q    <= prod[MW-1:0];
					state_q <= ST_PA;
				end
				ST_PA: begin
					x_q     <= prod[fpsnr_pkg::SSE_W-1:0];
					e_q     <= fpsnr_pkg::EXP_TOP;
					which_q <= 1'b0;
					state_q <= ST_NORM;
				end
				ST_NORM: begin
					if (x_q[fpsnr_pkg::SSE_W-1]) begin
						m_q     <= x_q[fpsnr_pkg::SSE_W-1 -: MW];
						frac_q  <= '0;
						rnd_q   <= '0;
						state_q <= ST_ITER;
					end else begin
						x_q <= {x_q[fpsnr_pkg::SSE_W-2:0], 1'b0};
						e_q <= e_q - fpsnr_pkg::EXP_W'(1);
					end
				end
				ST_ITER: begin
					frac_q <= frac_next;
					m_q    <= prod[2*MW-1] ? prod[2*MW-1:MW] : prod[2*MW-2:MW-1];
					rnd_q  <= rnd_q + 5'd1;
					if (rnd_q == 5'(fpsnr_pkg::LOG_FRAC - 1)) begin
						if (!which_q) begin
							la_q    <= log_val;
							x_q     <= sse_q;
							e_q     <= fpsnr_pkg::EXP_TOP;
							which_q <= 1'b1;
							state_q <= ST_NORM;
						end else if (la_q <= log_val) begin
							zero_q  <= 1'b1;
							state_q <= ST_FIN;
						end else begin
							dq_q    <= la_q - log_val;
							state_q <= ST_MH;
						end
					end
				end
				ST_MH: begin
					ph_q    <= prod[46:0];
					state_q <= ST_ML;
				end
				ST_ML: begin
					sc_q    <= total[2*MW-1:40];
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!out_valid_q || score_out.ready) begin
						out_valid_q <= 1'b1;
						out_score_q <= loss_q ? cap : capped;
						out_loss_q  <= loss_q;
						sse_q       <= '0;
						cnt_q       <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// squaring rounds always run on a normalized mantissa
	a_mant_norm: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ITER) |-> m_q[MW-1])
		else $error("mantissa not normalized in squaring round");

	a_norm_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NORM) |-> (x_q != '0))
		else $error("normalizing a zero operand");

	a_rnd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ITER) |-> (rnd_q < 5'(fpsnr_pkg::LOG_FRAC)))
		else $error("squaring round count overran");

	a_fin_sse: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && !out_valid_q) |=> (sse_q == '0 && state_q == ST_IDLE))
		else $error("frame sums not cleared after result");
endmodule
